// ----- src/validated_moving_average_lux_defines.svh -----
// Assertion macros shared by the validated moving average lux design.
`ifndef VALIDATED_MOVING_AVERAGE_LUX_DEFINES_SVH
`define VALIDATED_MOVING_AVERAGE_LUX_DEFINES_SVH
`ifndef SYNTHESIS
`define VMAL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VMAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VMAL_ASSERT(lbl, clk, rst, prop, msg)
`define VMAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/vmal_pkg.sv -----
// Types and constants shared by the validated moving average lux design.
package vmal_pkg;

   localparam int WINDOW_DEFAULT = 16;
   localparam int DATA_W         = 21;
   localparam int SAMPLE_W       = 22;
   localparam int APB_DATA_W     = 32;
   localparam int APB_ADDR_W     = 3;

   localparam logic [DATA_W-1:0] LUX_LIMIT = 21'd1920000;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   localparam logic REG_SENSOR_READY = 1'b0;
   localparam logic REG_THRESHOLD    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              sensor_ready;
      logic [DATA_W-1:0] threshold_lux;
   } cfg_type;

endpackage

// ----- src/vmal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vmal_ram #(
   parameter int WIDTH = vmal_pkg::DATA_W,
   parameter int DEPTH = vmal_pkg::WINDOW_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/vmal_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`include "validated_moving_average_lux_defines.svh"

module vmal_div #(
   parameter int SUM_W = 25,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  work_ff, work_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    diff;

   // The work register shifts the dividend out at the top and collects
   // quotient bits at the bottom.
   always_comb begin
      shifted = {rem_ff, work_ff[SUM_W-1]};
      diff    = shifted - {1'b0, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         work_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (!diff[CNT_W]) begin
            rem_in  = diff[CNT_W-1:0];
            work_in = {work_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[CNT_W-1:0];
            work_in = {work_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = work_ff;

   `VMAL_ASSERT(a_start_when_free, clock, reset, start |-> !busy_ff, "divider started while busy")
   `VMAL_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without run")
   `VMAL_ASSERT_NEXT(a_start_runs, clock, reset, start, busy_ff, "divider did not start")

endmodule

// ----- src/vmal_csr.sv -----
// Configuration registers behind the APB-style port.
module vmal_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [vmal_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [vmal_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [vmal_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output vmal_pkg::cfg_type                    cfg
);

   vmal_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_hit;
   logic              reg_sel;

   assign pready  = 1'b1;
   assign wr_hit  = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (reg_sel)
            vmal_pkg::REG_SENSOR_READY: cfg_in.sensor_ready  = pwdata[0];
            vmal_pkg::REG_THRESHOLD:    cfg_in.threshold_lux = pwdata[vmal_pkg::DATA_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         vmal_pkg::REG_SENSOR_READY:
            prdata = {{(vmal_pkg::APB_DATA_W-1){1'b0}}, cfg_ff.sensor_ready};
         vmal_pkg::REG_THRESHOLD:
            prdata = {{(vmal_pkg::APB_DATA_W-vmal_pkg::DATA_W){1'b0}}, cfg_ff.threshold_lux};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/validated_moving_average_lux.sv -----
// An accepted sample goes through the read and divide states, the divider giving one
// quotient bit per cycle, and then to the output state; a rejected sample or clear goes
// straight to the output state. One word is in flight; the next is taken the cycle after the
// result register loads, even while that result is stalled.
// Synchronous active-high reset empties the window and zeroes sum, average and last sample;
// the sample RAM is not cleared, since only entries written since the last clear are read.
`include "validated_moving_average_lux_defines.svh"

module validated_moving_average_lux #(
   parameter int WINDOW = vmal_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic signed [vmal_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                 req_sample_error,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [vmal_pkg::DATA_W-1:0]          rsp_average_lux,
   output logic                                 rsp_below_threshold,
   output logic [vmal_pkg::DATA_W-1:0]          rsp_raw_lux,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [vmal_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [vmal_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [vmal_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int DATA_W = vmal_pkg::DATA_W;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = DATA_W + $clog2(WINDOW);

   vmal_pkg::cfg_type   cfg;
   vmal_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]  write_index_ff, write_index_in;
   logic              window_full_ff, window_full_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [DATA_W-1:0] average_ff, average_in;
   logic [DATA_W-1:0] last_raw_ff, last_raw_in;
   logic [DATA_W-1:0] raw_ff, raw_in;
   logic              accepted_ff, accepted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff;
   logic [DATA_W-1:0] rsp_average_ff;
   logic              rsp_below_ff;
   logic [DATA_W-1:0] rsp_raw_ff;

   logic              req_take;
   logic              sample_good;
   logic              ram_rd_en;
   logic              ram_wr_en;
   logic [DATA_W-1:0] ram_rd_data;
   logic              div_start;
   logic              div_busy;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;
   logic              rsp_load;
   logic              out_free;

   logic [SUM_W-1:0]  old_value;
   logic [SUM_W-1:0]  sum_next;
   logic [CNT_W-1:0]  index_inc;
   logic              index_wrap;
   logic [CNT_W-1:0]  count_next;

   vmal_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vmal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_index_ff),
      .wr_data (raw_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (write_index_ff),
      .rd_data (ram_rd_data)
   );

   vmal_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (count_next),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_take = req_valid && !req_stall;
   assign out_free = !(rsp_valid_ff && rsp_stall);

   // A non-negative 22-bit value has a clear sign bit, so the low 21 bits carry it.
   assign sample_good = (req_func == vmal_pkg::FUNC_SAMPLE) && cfg.sensor_ready
                        && !req_sample_error && !req_sample_value[vmal_pkg::SAMPLE_W-1]
                        && (req_sample_value[DATA_W-1:0] <= vmal_pkg::LUX_LIMIT);

   // Once the window is full the entry about to be overwritten leaves the sum.
   assign old_value  = window_full_ff ? SUM_W'(ram_rd_data) : '0;
   assign sum_next   = running_sum_ff - old_value + SUM_W'(raw_ff);
   assign index_inc  = CNT_W'(write_index_ff) + CNT_W'(1);
   assign index_wrap = (index_inc == CNT_W'(WINDOW));
   assign count_next = (index_wrap || window_full_ff) ? CNT_W'(WINDOW) : index_inc;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vmal_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = sample_good ? vmal_pkg::ST_READ : vmal_pkg::ST_OUT;
            end
         end
         vmal_pkg::ST_READ: state_in = vmal_pkg::ST_DIV;
         vmal_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = vmal_pkg::ST_OUT;
            end
         end
         vmal_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = vmal_pkg::ST_IDLE;
            end
         end
         default: state_in = vmal_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         vmal_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ram_rd_en = req_take && sample_good;
         end
         vmal_pkg::ST_READ: begin
            ram_wr_en = 1'b1;
            div_start = 1'b1;
         end
         vmal_pkg::ST_DIV: begin
            req_stall = 1'b1;
         end
         vmal_pkg::ST_OUT: begin
            rsp_load = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      write_index_in = write_index_ff;
      window_full_in = window_full_ff;
      running_sum_in = running_sum_ff;
      average_in     = average_ff;
      last_raw_in    = last_raw_ff;
      raw_in         = raw_ff;
      accepted_in    = accepted_ff;
      if (req_take) begin
         raw_in      = req_sample_value[DATA_W-1:0];
         accepted_in = sample_good;
         if (req_func == vmal_pkg::FUNC_CLEAR) begin
            write_index_in = '0;
            window_full_in = 1'b0;
            running_sum_in = '0;
            average_in     = '0;
         end
      end
      if (div_start) begin
         running_sum_in = sum_next;
         last_raw_in    = raw_ff;
         write_index_in = index_wrap ? '0 : IDX_W'(index_inc);
         window_full_in = window_full_ff || index_wrap;
      end
      if (div_done) begin
         average_in = div_quotient[DATA_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= vmal_pkg::ST_IDLE;
         write_index_ff <= '0;
         window_full_ff <= 1'b0;
         running_sum_ff <= '0;
         average_ff     <= '0;
         last_raw_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         window_full_ff <= window_full_in;
         running_sum_ff <= running_sum_in;
         average_ff     <= average_in;
         last_raw_ff    <= last_raw_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      raw_ff      <= raw_in;
      accepted_ff <= accepted_in;
      if (rsp_load) begin
         rsp_accepted_ff <= accepted_ff;
         rsp_average_ff  <= average_ff;
         rsp_below_ff    <= (average_ff < cfg.threshold_lux);
         rsp_raw_ff      <= last_raw_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_average_lux     = rsp_average_ff;
   assign rsp_below_threshold = rsp_below_ff;
   assign rsp_raw_lux         = rsp_raw_ff;

   `VMAL_ASSERT(a_average_bound, clock, reset, average_ff <= vmal_pkg::LUX_LIMIT, "average out of range")
   `VMAL_ASSERT(a_empty_sum, clock, reset, (!window_full_ff && write_index_ff == '0) |-> (running_sum_ff == '0), "empty window has a sum")
   `VMAL_ASSERT(a_div_nonempty, clock, reset, (state_ff == vmal_pkg::ST_DIV) |-> (window_full_ff || write_index_ff != '0), "division by an empty window")
   `VMAL_ASSERT(a_div_idle_state, clock, reset, div_busy |-> (state_ff == vmal_pkg::ST_DIV), "divider runs outside its state")

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the validated moving average lux filter.
`timescale 1ns / 100ps

module testbench;

   localparam int DATA_W         = vmal_pkg::DATA_W;
   localparam int SAMPLE_W       = vmal_pkg::SAMPLE_W;
   localparam int APB_ADDR_W     = vmal_pkg::APB_ADDR_W;
   localparam int APB_DATA_W     = vmal_pkg::APB_DATA_W;
   localparam int WINDOW_DEFAULT = vmal_pkg::WINDOW_DEFAULT;
   localparam int LUX_MAX        = int'(vmal_pkg::LUX_LIMIT);
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic              accepted;
      logic [DATA_W-1:0] average_lux;
      logic              below_threshold;
      logic [DATA_W-1:0] raw_lux;
   } lux_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_func = vmal_pkg::FUNC_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic                      req_sample_error = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_accepted;
   logic [DATA_W-1:0]         rsp_average_lux;
   logic                      rsp_below_threshold;
   logic [DATA_W-1:0]         rsp_raw_lux;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [APB_ADDR_W-1:0]     paddr = '0;
   logic [APB_DATA_W-1:0]     pwdata = '0;
   logic [APB_DATA_W-1:0]     prdata;
   logic                      pready;

   // Shadow of the filter: configuration, window contents and running sum.
   logic              cfg_ready = 1'b0;
   logic [DATA_W-1:0] cfg_threshold = '0;
   logic [DATA_W-1:0] win_store [WINDOW_DEFAULT];
   int                win_idx = 0;
   logic              win_full = 1'b0;
   logic [24:0]       win_sum = '0;
   logic [DATA_W-1:0] win_avg = '0;
   logic [DATA_W-1:0] win_last = '0;

   lux_result_type lux_expected [$];
   int             error_count = 0;
   bit             send_gaps_on = 1'b0;
   bit             stall_bursts_on = 1'b0;
   int             hold_cycles = 0;

   always #5 clock = ~clock;

   validated_moving_average_lux uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_sample_value    (req_sample_value),
      .req_sample_error    (req_sample_error),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_average_lux     (rsp_average_lux),
      .rsp_below_threshold (rsp_below_threshold),
      .rsp_raw_lux         (rsp_raw_lux),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   task automatic predict_lux_result(input logic func, input logic [SAMPLE_W-1:0] raw,
                                     input logic err);
      lux_result_type r;
      int             stored;
      logic [31:0]    quotient;
      r.accepted = 1'b0;
      if (func == vmal_pkg::FUNC_CLEAR) begin
         win_idx  = 0;
         win_full = 1'b0;
         win_sum  = '0;
         win_avg  = '0;
      end else if (cfg_ready && !err && !raw[SAMPLE_W-1]
                   && raw[DATA_W-1:0] <= vmal_pkg::LUX_LIMIT) begin
         // Once the window has wrapped, the slot being overwritten leaves the sum.
         if (win_full)
            win_sum -= win_store[win_idx];
         win_store[win_idx] = raw[DATA_W-1:0];
         win_sum += raw[DATA_W-1:0];
         win_last = raw[DATA_W-1:0];
         if (win_idx == WINDOW_DEFAULT - 1) begin
            win_idx  = 0;
            win_full = 1'b1;
         end else begin
            win_idx++;
         end
         stored   = win_full ? WINDOW_DEFAULT : win_idx;
         quotient = win_sum / stored;
         win_avg  = quotient[DATA_W-1:0];
         r.accepted = 1'b1;
      end
      r.average_lux     = win_avg;
      r.below_threshold = win_avg < cfg_threshold;
      r.raw_lux         = win_last;
      lux_expected.push_back(r);
   endtask

   // Offers one word; valid stays high afterwards so back-to-back words need no re-raise.
   task automatic send_word(input logic func, input int sample, input logic err);
      int gap;
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_sample_value <= sample[SAMPLE_W-1:0];
      req_sample_error <= err;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lux_result(func, sample[SAMPLE_W-1:0], err);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (lux_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_transfer(input logic idx, input logic is_write,
                               input logic [APB_DATA_W-1:0] wdata,
                               output logic [APB_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic write_register(input logic idx, input int unsigned value);
      logic [APB_DATA_W-1:0] rdata;
      logic [APB_DATA_W-1:0] want;
      apb_transfer(idx, 1'b1, value, rdata);
      if (idx == vmal_pkg::REG_SENSOR_READY) begin
         cfg_ready = value[0];
         want = {31'b0, cfg_ready};
      end else begin
         cfg_threshold = value[DATA_W-1:0];
         want = {11'b0, cfg_threshold};
      end
      @(posedge clock);
      apb_transfer(idx, 1'b0, '0, rdata);
      check_field("register readback", want, rdata);
      @(posedge clock);
   endtask

   // Result checker: every taken word is matched against the oldest prediction.
   always @(posedge clock) begin
      lux_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lux_expected.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, expected none, actual avg %0d raw %0d",
                     $time, rsp_average_lux, rsp_raw_lux);
         end else begin
            want = lux_expected.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("average_lux", 32'(want.average_lux), 32'(rsp_average_lux));
            check_field("below_threshold", 32'(want.below_threshold),
                        32'(rsp_below_threshold));
            check_field("raw_lux", 32'(want.raw_lux), 32'(rsp_raw_lux));
         end
      end
   end

   // Receiver stall: a long hold when requested, otherwise optional random bursts.
   always begin
      @(posedge clock);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         hold_cycles = 0;
         rsp_stall <= 1'b0;
      end else if (stall_bursts_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_reset_state();
      logic [APB_DATA_W-1:0] rdata;
      apb_transfer(vmal_pkg::REG_SENSOR_READY, 1'b0, '0, rdata);
      check_field("sensor_ready after reset", 0, rdata);
      @(posedge clock);
      apb_transfer(vmal_pkg::REG_THRESHOLD, 1'b0, '0, rdata);
      check_field("threshold_lux after reset", 0, rdata);
      @(posedge clock);
      // Sensor not ready yet, so a good sample is turned away; a clear still works.
      send_word(vmal_pkg::FUNC_SAMPLE, 1000, 1'b0);
      send_word(vmal_pkg::FUNC_CLEAR, 0, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_field_extremes();
      write_register(vmal_pkg::REG_SENSOR_READY, 1);
      write_register(vmal_pkg::REG_THRESHOLD, LUX_MAX);
      send_word(vmal_pkg::FUNC_SAMPLE, 0, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, LUX_MAX, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, LUX_MAX + 1, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, 2097151, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, -1, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, -2097152, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, 5000, 1'b1);
      send_word(vmal_pkg::FUNC_CLEAR, -2097152, 1'b1);
      send_word(vmal_pkg::FUNC_SAMPLE, 1, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_window_wrap();
      write_register(vmal_pkg::REG_THRESHOLD, LUX_MAX / 2);
      send_word(vmal_pkg::FUNC_CLEAR, 0, 1'b0);
      // A full window of maximum samples gives the largest sum; one more wraps it.
      repeat (WINDOW_DEFAULT) send_word(vmal_pkg::FUNC_SAMPLE, LUX_MAX, 1'b0);
      send_word(vmal_pkg::FUNC_SAMPLE, 0, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      send_gaps_on    = 1'b0;
      stall_bursts_on = 1'b0;
      hold_cycles     = 300;
      repeat (12) send_word(vmal_pkg::FUNC_SAMPLE, $urandom_range(0, LUX_MAX), 1'b0);
      wait_for_drain();
   endtask

   task automatic run_random_phase(input int items);
      int   kind;
      int   sample;
      logic func;
      logic err;
      repeat (items) begin
         kind   = $urandom_range(0, 99);
         func   = vmal_pkg::FUNC_SAMPLE;
         err    = 1'b0;
         sample = 0;
         if (kind < 70) begin
            sample = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, LUX_MAX);
         end else if (kind < 76) begin
            func   = vmal_pkg::FUNC_CLEAR;
            sample = $urandom_range(0, 4194303);
            err    = 1'($urandom_range(0, 1));
         end else if (kind < 82) begin
            sample = $urandom_range(0, LUX_MAX);
            err    = 1'b1;
         end else if (kind < 88) begin
            sample = -int'($urandom_range(1, 2097152));
         end else if (kind < 94) begin
            sample = $urandom_range(LUX_MAX + 1, 2097151);
         end else begin
            func   = 1'($urandom_range(0, 1));
            sample = $urandom_range(0, 4194303);
            err    = 1'($urandom_range(0, 1));
         end
         send_word(func, sample, err);
      end
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      send_gaps_on    = 1'b1;
      stall_bursts_on = 1'b1;
      write_register(vmal_pkg::REG_THRESHOLD, $urandom_range(0, LUX_MAX));
      run_random_phase(120);
      write_register(vmal_pkg::REG_SENSOR_READY, 0);
      run_random_phase(30);
      write_register(vmal_pkg::REG_SENSOR_READY, 1);
      write_register(vmal_pkg::REG_THRESHOLD, 0);
      run_random_phase(100);
      write_register(vmal_pkg::REG_THRESHOLD, LUX_MAX);
      run_random_phase(100);
      // Final stretch runs at full rate on both sides.
      send_gaps_on    = 1'b0;
      stall_bursts_on = 1'b0;
      write_register(vmal_pkg::REG_THRESHOLD, $urandom_range(0, LUX_MAX));
      run_random_phase(150);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_field_extremes();
      test_window_wrap();
      test_backpressure();
      test_random_traffic();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
